FILE: src/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg - shared types, constants and arithmetic for the fractal iterator
// Coordinate format, saturating helpers, formula term tables and the
// sequencer state type of the back half of the core.
// ----------------------------------------------------------------------------
package etf_pkg;

	// Coordinate format: signed Q(CW-FB).FB
	localparam int CW        = 64;
	localparam int FB        = 56;
	localparam int MAG_FRAC  = 48;
	localparam int MAG_SHIFT = 2 * FB - MAG_FRAC;
	localparam int HALF_LO   = CW / 2;
	localparam int HALF_HI   = CW - HALF_LO;
	localparam int QDEPTH    = 2;

	typedef logic [CW-1:0] coord_t;

	localparam coord_t CMAX = coord_t'({1'b0, {(CW-1){1'b1}}});
	localparam coord_t CMIN = coord_t'({1'b1, {(CW-1){1'b0}}});

	localparam logic [63:0] LOW_START = 64'd4 << MAG_FRAC;
	localparam logic [63:0] ESC_LIMIT = 64'd4096 << MAG_FRAC;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_DEGREE   = 3'd0,
		REG_FORMULA  = 3'd1,
		REG_JULIA    = 3'd2,
		REG_PARAM_RE = 3'd3,
		REG_PARAM_IM = 3'd4,
		REG_MAX_ITER = 3'd5
	} cfg_reg_e;

	localparam logic [2:0]  RST_DEGREE   = 3'd2;
	localparam logic [15:0] RST_MAX_ITER = 16'd256;
	localparam logic [1:0]  JULIA_BIT    = 2'h1;
	localparam logic [1:0]  ZERO_BIT     = 2'h2;

	typedef struct packed {
		logic signed [63:0] point_re;
		logic signed [63:0] point_im;
	} point_t;

	typedef struct packed {
		logic        escaped;
		logic [15:0] escape_iter;
		logic [63:0] escape_mag_sq;
		logic [63:0] min_mag_sq;
	} result_t;

	typedef struct packed {
		logic [2:0]  degree;
		logic [19:0] formula_bits;
		logic [15:0] max_iter;
	} cfg_t;

	typedef struct packed {
		coord_t zr;
		coord_t zi;
		coord_t cr;
		coord_t ci;
	} job_t;

	typedef struct packed {
		logic   ovf;
		coord_t val;
	} sat_t;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_SUB = 2'd1,
		OP_ADD = 2'd2
	} op_e;

	// One polynomial term: product of factors, coefficient, sign, combine op
	typedef struct packed {
		logic [2:0]      nfac;
		logic [4:0]      fim;
		logic [4:0]      fabs;
		logic [4:0][4:0] fbit;
		logic [3:0]      k;
		logic            sgn_en;
		logic [4:0]      sbit;
		op_e             op;
		logic            last;
		logic            im;
	} term_t;

	typedef struct packed {
		logic       abs_en;
		logic [4:0] abs_bit;
		logic       sgn_en;
		logic [4:0] sgn_bit;
	} outer_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ITER,
		ST_TERM,
		ST_MUL,
		ST_MWAIT,
		ST_COEF,
		ST_COMB,
		ST_OUTER,
		ST_MAGA,
		ST_MAGAW,
		ST_MAGB,
		ST_MAGBW,
		ST_MEVAL,
		ST_DONE
	} bst_e;

	function automatic sat_t f_neg(coord_t a);
		sat_t r;
		r.ovf = (a == CMIN);
		r.val = r.ovf ? CMAX : (coord_t'(0) - a);
		return r;
	endfunction

	function automatic sat_t f_abs(coord_t a);
		sat_t r;
		r.ovf = 1'b0;
		r.val = a;
		if (a[CW-1]) r = f_neg(a);
		return r;
	endfunction

	function automatic coord_t f_mag(coord_t a);
		return a[CW-1] ? (coord_t'(0) - a) : a;
	endfunction

	function automatic sat_t f_add(coord_t a, coord_t b);
		logic [CW:0] s;
		sat_t r;
		s = {a[CW-1], a} + {b[CW-1], b};
		r.ovf = s[CW] ^ s[CW-1];
		r.val = r.ovf ? (s[CW] ? CMIN : CMAX) : s[CW-1:0];
		return r;
	endfunction

	function automatic sat_t f_sub(coord_t a, coord_t b);
		logic [CW:0] s;
		sat_t r;
		s = {a[CW-1], a} - {b[CW-1], b};
		r.ovf = s[CW] ^ s[CW-1];
		r.val = r.ovf ? (s[CW] ? CMIN : CMAX) : s[CW-1:0];
		return r;
	endfunction

	function automatic sat_t f_coef(logic [3:0] k, coord_t x);
		logic signed [CW+4:0] p;
		sat_t r;
		p = $signed({{5{x[CW-1]}}, x}) * $signed({1'b0, k});
		r.ovf = (p[CW+4:CW-1] != {6{p[CW+4]}});
		r.val = r.ovf ? (p[CW+4] ? CMIN : CMAX) : p[CW-1:0];
		return r;
	endfunction

	function automatic term_t mk_term(logic [2:0] nfac, logic [4:0] fim, logic [4:0] fabs,
			logic [24:0] fbit, logic [3:0] k, logic sgn_en, logic [4:0] sbit,
			op_e op, logic last, logic im);
		term_t t;
		t.nfac   = nfac;
		t.fim    = fim;
		t.fabs   = fabs;
		t.fbit   = fbit;
		t.k      = k;
		t.sgn_en = sgn_en;
		t.sbit   = sbit;
		t.op     = op;
		t.last   = last;
		t.im     = im;
		return t;
	endfunction

	// Term tables per degree; degrees other than 3..5 run the quadratic family
	function automatic term_t term_desc(logic [2:0] deg, logic [2:0] t);
		term_t d;
		d = mk_term(3'd2, 5'b0, 5'b0, 25'd0, 4'd1, 1'b0, 5'd0, OP_SET, 1'b1, 1'b1);
		unique case (deg)
			3'd3: begin
				case (t)
					3'd0: d = mk_term(3'd3, 5'b00000, 5'b00001, {20'd0, 5'd6},
						4'd1, 1'b1, 5'd0, OP_SET, 1'b0, 1'b0);
					3'd1: d = mk_term(3'd3, 5'b00110, 5'b00011, {15'd0, 5'd7, 5'd8},
						4'd3, 1'b1, 5'd1, OP_SUB, 1'b1, 1'b0);
					3'd2: d = mk_term(3'd3, 5'b00100, 5'b00101, {10'd0, 5'd9, 5'd0, 5'd10},
						4'd3, 1'b1, 5'd2, OP_SET, 1'b0, 1'b1);
					3'd3: d = mk_term(3'd3, 5'b00111, 5'b00001, {20'd0, 5'd11},
						4'd1, 1'b1, 5'd3, OP_SUB, 1'b1, 1'b1);
					default: ;
				endcase
			end
			3'd4: begin
				case (t)
					3'd0: d = mk_term(3'd4, 5'b00000, 5'b00001, {20'd0, 5'd7},
						4'd1, 1'b1, 5'd0, OP_SET, 1'b0, 1'b0);
					3'd1: d = mk_term(3'd4, 5'b01100, 5'b00101, {10'd0, 5'd8, 5'd0, 5'd9},
						4'd6, 1'b1, 5'd1, OP_SUB, 1'b0, 1'b0);
					3'd2: d = mk_term(3'd4, 5'b01111, 5'b00001, {20'd0, 5'd10},
						4'd1, 1'b1, 5'd2, OP_ADD, 1'b1, 1'b0);
					3'd3: d = mk_term(3'd4, 5'b01000, 5'b01001,
						{5'd0, 5'd12, 10'd0, 5'd11}, 4'd4, 1'b1, 5'd3, OP_SET, 1'b0, 1'b1);
					3'd4: d = mk_term(3'd4, 5'b01110, 5'b00011, {15'd0, 5'd14, 5'd13},
						4'd4, 1'b1, 5'd4, OP_SUB, 1'b1, 1'b1);
					default: ;
				endcase
			end
			3'd5: begin
				case (t)
					3'd0: d = mk_term(3'd5, 5'b00000, 5'b00001, {20'd0, 5'd8},
						4'd1, 1'b1, 5'd0, OP_SET, 1'b0, 1'b0);
					3'd1: d = mk_term(3'd5, 5'b11000, 5'b01001,
						{5'd0, 5'd9, 10'd0, 5'd10}, 4'd10, 1'b1, 5'd1, OP_SUB, 1'b0, 1'b0);
					3'd2: d = mk_term(3'd5, 5'b11110, 5'b00011, {15'd0, 5'd11, 5'd12},
						4'd5, 1'b1, 5'd2, OP_ADD, 1'b1, 1'b0);
					3'd3: d = mk_term(3'd5, 5'b10000, 5'b10001, {5'd13, 15'd0, 5'd14},
						4'd5, 1'b1, 5'd3, OP_SET, 1'b0, 1'b1);
					3'd4: d = mk_term(3'd5, 5'b11100, 5'b00101,
						{10'd0, 5'd15, 5'd0, 5'd16}, 4'd10, 1'b1, 5'd4, OP_SUB, 1'b0, 1'b1);
					3'd5: d = mk_term(3'd5, 5'b11111, 5'b00001, {20'd0, 5'd17},
						4'd1, 1'b1, 5'd5, OP_ADD, 1'b1, 1'b1);
					default: ;
				endcase
			end
			default: begin
				case (t)
					3'd0: d = mk_term(3'd2, 5'b00000, 5'b00001, {20'd0, 5'd3},
						4'd1, 1'b0, 5'd0, OP_SET, 1'b0, 1'b0);
					3'd1: d = mk_term(3'd2, 5'b00011, 5'b00001, {20'd0, 5'd4},
						4'd1, 1'b1, 5'd1, OP_SUB, 1'b1, 1'b0);
					3'd2: d = mk_term(3'd2, 5'b00010, 5'b00011, {15'd0, 5'd6, 5'd5},
						4'd2, 1'b1, 5'd2, OP_SET, 1'b1, 1'b1);
					default: ;
				endcase
			end
		endcase
		return d;
	endfunction

	// Outer abs and sign per part; quadratic imaginary part has none
	function automatic outer_t outer_desc(logic [2:0] deg, logic im);
		outer_t o;
		unique case (deg)
			3'd3: o = im ? outer_t'{1'b1, 5'd13, 1'b1, 5'd5} : outer_t'{1'b1, 5'd12, 1'b1, 5'd4};
			3'd4: o = im ? outer_t'{1'b1, 5'd16, 1'b1, 5'd6} : outer_t'{1'b1, 5'd15, 1'b1, 5'd5};
			3'd5: o = im ? outer_t'{1'b1, 5'd19, 1'b1, 5'd7} : outer_t'{1'b1, 5'd18, 1'b1, 5'd6};
			default: o = im ? outer_t'{1'b0, 5'd0, 1'b0, 5'd0} : outer_t'{1'b1, 5'd7, 1'b1, 5'd0};
		endcase
		return o;
	endfunction

endpackage

FILE: src/etf_front.sv
// ----------------------------------------------------------------------------
// etf_front - configuration registers, point intake and job queue
// Holds the registers, turns each accepted point into a start value and
// a constant according to the Julia mode, and queues it for the back end.
// ----------------------------------------------------------------------------
module etf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  etf_pkg::point_t  point,
	output logic             full,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	output etf_pkg::cfg_t    cfg,
	output logic             job_valid,
	output etf_pkg::job_t    job,
	input  logic             job_take
);

	localparam int PW = $clog2(etf_pkg::QDEPTH);

	logic [2:0]            degree_q;
	logic [19:0]           formula_q;
	logic [1:0]            julia_q;
	etf_pkg::coord_t       param_re_q;
	etf_pkg::coord_t       param_im_q;
	logic [15:0]           max_iter_q;

	etf_pkg::job_t         mem_q [etf_pkg::QDEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;
	etf_pkg::job_t         new_job;
	etf_pkg::coord_t       pr;
	etf_pkg::coord_t       pi;
	logic                  do_push;
	logic                  do_pop;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q   <= etf_pkg::RST_DEGREE;
			formula_q  <= '0;
			julia_q    <= '0;
			param_re_q <= '0;
			param_im_q <= '0;
			max_iter_q <= etf_pkg::RST_MAX_ITER;
		end else if (cfg_we) begin
			unique case (etf_pkg::cfg_reg_e'(cfg_index))
				etf_pkg::REG_DEGREE:   degree_q   <= cfg_data[2:0];
				etf_pkg::REG_FORMULA:  formula_q  <= cfg_data[19:0];
				etf_pkg::REG_JULIA:    julia_q    <= cfg_data[1:0];
				etf_pkg::REG_PARAM_RE: param_re_q <= cfg_data[etf_pkg::CW-1:0];
				etf_pkg::REG_PARAM_IM: param_im_q <= cfg_data[etf_pkg::CW-1:0];
				etf_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{degree: degree_q, formula_bits: formula_q, max_iter: max_iter_q};

	// Classify the point: Julia swaps the roles of start value and constant
	always_comb begin
		pr = point.point_re[etf_pkg::CW-1:0];
		pi = point.point_im[etf_pkg::CW-1:0];
		if ((julia_q & etf_pkg::JULIA_BIT) != 2'b0) begin
			new_job = '{zr: pr, zi: pi, cr: param_re_q, ci: param_im_q};
		end else if ((julia_q & etf_pkg::ZERO_BIT) != 2'b0) begin
			new_job = '{zr: '0, zi: '0, cr: pr, ci: pi};
		end else begin
			new_job = '{zr: param_re_q, zi: param_im_q, cr: pr, ci: pi};
		end
	end

	assign full      = (count_q == (PW+1)'(etf_pkg::QDEPTH));
	assign job_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = job_take && job_valid;
	assign job       = mem_q[rd_ptr_q];

	// Store queued jobs
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= new_job;
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

endmodule

FILE: src/etf_mul.sv
// ----------------------------------------------------------------------------
// etf_mul - multi-cycle unsigned coordinate multiplier
// Forms the exact double-width product of two magnitudes from four
// half-width partial products, one per cycle, registered before the add.
// ----------------------------------------------------------------------------
module etf_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  etf_pkg::coord_t            op_a,
	input  etf_pkg::coord_t            op_b,
	output logic                       done,
	output logic [2*etf_pkg::CW-1:0]   prod
);

	localparam int LO = etf_pkg::HALF_LO;
	localparam int HI = etf_pkg::HALF_HI;
	localparam int PP = 2 * HI;
	localparam int PWD = 2 * etf_pkg::CW;

	typedef logic [PP-1:0] pp_t;

	etf_pkg::coord_t a_q;
	etf_pkg::coord_t b_q;
	pp_t             pp_q;
	pp_t             pp;
	logic [PWD-1:0]  acc_q;
	logic [PWD-1:0]  addend;
	logic [2:0]      cnt_q;
	logic [1:0]      prev;
	logic            busy_q;
	logic            done_q;
	logic [HI-1:0]   xa;
	logic [HI-1:0]   xb;

	// Select the partial product for this cycle
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin xa = HI'(a_q[LO-1:0]);             xb = HI'(b_q[LO-1:0]); end
			2'd1: begin xa = HI'(a_q[LO-1:0]);             xb = b_q[etf_pkg::CW-1:LO]; end
			2'd2: begin xa = a_q[etf_pkg::CW-1:LO];        xb = HI'(b_q[LO-1:0]); end
			default: begin xa = a_q[etf_pkg::CW-1:LO];     xb = b_q[etf_pkg::CW-1:LO]; end
		endcase
		pp = pp_t'(xa) * pp_t'(xb);
	end

	// Align the previous partial product
	always_comb begin
		prev = cnt_q[1:0] - 2'd1;
		unique case (prev)
			2'd0:    addend = PWD'(pp_q);
			2'd1,
			2'd2:    addend = PWD'(pp_q) << LO;
			default: addend = PWD'(pp_q) << (2 * LO);
		endcase
	end

	// Latch operands and accumulate
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) pp_q <= pp;
			if (cnt_q >= 3'd1) acc_q <= acc_q + addend;
		end
	end

	// Step the partial product counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: src/etf_back.sv
// ----------------------------------------------------------------------------
// etf_back - iteration sequencer and result register
// Walks the formula terms of each step through the shared multiplier,
// applies coefficients, signs and saturation, tracks |z|^2 and escape.
// ----------------------------------------------------------------------------
module etf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  etf_pkg::job_t    job,
	output logic             job_take,
	input  etf_pkg::cfg_t    cfg,
	output logic             res_valid,
	input  logic             pop,
	output etf_pkg::result_t result
);

	localparam int CW = etf_pkg::CW;

	etf_pkg::bst_e    state_q;
	etf_pkg::bst_e    state_d;
	etf_pkg::coord_t  zr_q, zi_q, cr_q, ci_q;
	etf_pkg::coord_t  prod_q, term_q, sum_q, nr_q;
	logic             neg_q;
	logic             ovf_q;
	logic [2:0]       t_q;
	logic [2:0]       fidx_q;
	logic [15:0]      it_q;
	logic [63:0]      low_q;
	logic [63:0]      emag_q;
	logic             esc_q;
	logic [2*CW-1:0]  maga_q;
	logic             res_valid_q;
	etf_pkg::result_t res_q;

	etf_pkg::term_t   td;
	etf_pkg::outer_t  od;
	etf_pkg::sat_t    pk;
	etf_pkg::sat_t    cf, cn, cb, oa, on, oc;
	etf_pkg::coord_t  fsel;
	etf_pkg::coord_t  mul_a, mul_b, mres, mval;
	logic             mul_start, mul_done;
	logic [2*CW-1:0]  mprod, psh, lim;
	logic             movf;
	logic [2*CW:0]    msum, msh;
	logic [63:0]      zs;
	logic             res_load;

	assign td = etf_pkg::term_desc(cfg.degree, t_q);
	assign od = etf_pkg::outer_desc(cfg.degree, td.im);

	// Pick the current factor, with its optional absolute value
	always_comb begin
		fsel = td.fim[fidx_q] ? zi_q : zr_q;
		pk   = '{ovf: 1'b0, val: fsel};
		if (td.fabs[fidx_q] && cfg.formula_bits[td.fbit[fidx_q]]) pk = etf_pkg::f_abs(fsel);
	end

	// Route operands to the shared multiplier
	always_comb begin
		mul_a = (state_q == etf_pkg::ST_MUL) ? etf_pkg::f_mag(prod_q) :
			(state_q == etf_pkg::ST_MAGA) ? etf_pkg::f_mag(zr_q) : etf_pkg::f_mag(zi_q);
		mul_b = (state_q == etf_pkg::ST_MUL) ? etf_pkg::f_mag(pk.val) : mul_a;
	end

	etf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (mprod)
	);

	// Truncate and saturate a coordinate product
	always_comb begin
		psh  = mprod >> etf_pkg::FB;
		lim  = {{(CW+1){1'b0}}, {(CW-1){1'b1}}} + (2*CW)'(neg_q);
		movf = (psh > lim);
		mval = movf ? lim[CW-1:0] : psh[CW-1:0];
		mres = neg_q ? (etf_pkg::coord_t'(0) - mval) : mval;
	end

	// Coefficient, term sign and combine
	always_comb begin
		cf = etf_pkg::f_coef(td.k, prod_q);
		cn = cf;
		if (td.sgn_en && cfg.formula_bits[td.sbit]) begin
			cn = etf_pkg::f_neg(cf.val);
			cn.ovf = cn.ovf | cf.ovf;
		end
		unique case (td.op)
			etf_pkg::OP_SUB: cb = etf_pkg::f_sub(sum_q, term_q);
			etf_pkg::OP_ADD: cb = etf_pkg::f_add(sum_q, term_q);
			default:         cb = '{ovf: 1'b0, val: term_q};
		endcase
	end

	// Outer abs, outer sign and the constant
	always_comb begin
		oa = '{ovf: 1'b0, val: sum_q};
		if (od.abs_en && cfg.formula_bits[od.abs_bit]) oa = etf_pkg::f_abs(sum_q);
		on = oa;
		if (od.sgn_en && cfg.formula_bits[od.sgn_bit]) begin
			on = etf_pkg::f_neg(oa.val);
			on.ovf = on.ovf | oa.ovf;
		end
		oc = etf_pkg::f_add(on.val, td.im ? ci_q : cr_q);
		oc.ovf = oc.ovf | on.ovf;
	end

	// Magnitude squared in Q16.48, forced to all ones after overflow
	always_comb begin
		msum = {1'b0, maga_q} + {1'b0, mprod};
		msh  = msum >> etf_pkg::MAG_SHIFT;
		zs   = (ovf_q || (|msh[2*CW:64])) ? '1 : msh[63:0];
	end

	assign res_load = (state_q == etf_pkg::ST_DONE) && (!res_valid_q || pop);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= etf_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state and handshakes
	always_comb begin
		state_d   = state_q;
		job_take  = 1'b0;
		mul_start = 1'b0;
		unique case (state_q)
			etf_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					state_d  = etf_pkg::ST_ITER;
				end
			end
			etf_pkg::ST_ITER:
				state_d = (it_q == cfg.max_iter) ? etf_pkg::ST_DONE : etf_pkg::ST_TERM;
			etf_pkg::ST_TERM:  state_d = etf_pkg::ST_MUL;
			etf_pkg::ST_MUL: begin
				mul_start = 1'b1;
				state_d   = etf_pkg::ST_MWAIT;
			end
			etf_pkg::ST_MWAIT: begin
				if (mul_done)
					state_d = ((fidx_q + 3'd1) == td.nfac) ? etf_pkg::ST_COEF : etf_pkg::ST_MUL;
			end
			etf_pkg::ST_COEF:  state_d = etf_pkg::ST_COMB;
			etf_pkg::ST_COMB:  state_d = td.last ? etf_pkg::ST_OUTER : etf_pkg::ST_TERM;
			etf_pkg::ST_OUTER: state_d = td.im ? etf_pkg::ST_MAGA : etf_pkg::ST_TERM;
			etf_pkg::ST_MAGA: begin
				mul_start = 1'b1;
				state_d   = etf_pkg::ST_MAGAW;
			end
			etf_pkg::ST_MAGAW: if (mul_done) state_d = etf_pkg::ST_MAGB;
			etf_pkg::ST_MAGB: begin
				mul_start = 1'b1;
				state_d   = etf_pkg::ST_MAGBW;
			end
			etf_pkg::ST_MAGBW: if (mul_done) state_d = etf_pkg::ST_MEVAL;
			etf_pkg::ST_MEVAL: begin
				if (zs < low_q) state_d = etf_pkg::ST_ITER;
				else if (zs > etf_pkg::ESC_LIMIT) state_d = etf_pkg::ST_DONE;
				else state_d = etf_pkg::ST_ITER;
			end
			etf_pkg::ST_DONE:  if (res_load) state_d = etf_pkg::ST_IDLE;
			default:           state_d = etf_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			etf_pkg::ST_IDLE: begin
				zr_q   <= job.zr;
				zi_q   <= job.zi;
				cr_q   <= job.cr;
				ci_q   <= job.ci;
				it_q   <= '0;
				low_q  <= etf_pkg::LOW_START;
				emag_q <= '0;
				esc_q  <= 1'b0;
			end
			etf_pkg::ST_ITER: begin
				ovf_q  <= 1'b0;
				t_q    <= '0;
				fidx_q <= '0;
			end
			etf_pkg::ST_TERM: begin
				prod_q <= pk.val;
				ovf_q  <= ovf_q | pk.ovf;
				fidx_q <= 3'd1;
			end
			etf_pkg::ST_MUL: begin
				neg_q <= prod_q[CW-1] ^ pk.val[CW-1];
				ovf_q <= ovf_q | pk.ovf;
			end
			etf_pkg::ST_MWAIT: begin
				if (mul_done) begin
					prod_q <= mres;
					ovf_q  <= ovf_q | movf;
					fidx_q <= fidx_q + 3'd1;
				end
			end
			etf_pkg::ST_COEF: begin
				term_q <= cn.val;
				ovf_q  <= ovf_q | cn.ovf;
			end
			etf_pkg::ST_COMB: begin
				sum_q  <= cb.val;
				ovf_q  <= ovf_q | cb.ovf;
				fidx_q <= '0;
				if (!td.last) t_q <= t_q + 3'd1;
			end
			etf_pkg::ST_OUTER: begin
				ovf_q <= ovf_q | oc.ovf;
				if (td.im) begin
					zr_q <= nr_q;
					zi_q <= oc.val;
				end else begin
					nr_q <= oc.val;
					t_q  <= t_q + 3'd1;
				end
			end
			etf_pkg::ST_MAGAW: if (mul_done) maga_q <= mprod;
			etf_pkg::ST_MEVAL: begin
				if (zs < low_q) begin
					low_q <= zs;
					it_q  <= it_q + 16'd1;
				end else if (zs > etf_pkg::ESC_LIMIT) begin
					esc_q  <= 1'b1;
					emag_q <= zs;
				end else begin
					it_q <= it_q + 16'd1;
				end
			end
			default: ;
		endcase
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.escaped       <= esc_q;
			res_q.escape_iter   <= it_q;
			res_q.escape_mag_sq <= emag_q;
			res_q.min_mag_sq    <= low_q;
		end
	end

	// Track result occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       res_valid_q <= 1'b0;
		else if (res_load) res_valid_q <= 1'b1;
		else if (pop)      res_valid_q <= 1'b0;
	end

	assign res_valid = res_valid_q;
	assign result    = res_q;

endmodule

FILE: src/escape_time_fractal_iterator_core.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_core - escape-time fractal iterator
// Queue-style point intake, formula sequencer and queue-style result port.
// ----------------------------------------------------------------------------
// Each pushed point is iterated with z = f(z) + c (degree 2 to 5, signs and
// absolute values from formula_bits) until |z|^2 exceeds 4096 or max_iter
// steps have run; one result per point comes out in order. All multiplies go
// through one shared 64x64 unit built from four 32x32 partial products.
// A two-entry queue takes new points while the sequencer works, and the
// result register lets the next point start while a result waits to be
// popped.
module escape_time_fractal_iterator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  etf_pkg::point_t   point,
	output logic              empty,
	input  logic              pop,
	output etf_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	etf_pkg::cfg_t cfg;
	etf_pkg::job_t job;
	logic          job_valid;
	logic          job_take;
	logic          res_valid;

	etf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.point     (point),
		.full      (full),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	etf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.cfg       (cfg),
		.res_valid (res_valid),
		.pop       (pop),
		.result    (result)
	);

	assign empty = !res_valid;

`ifndef NO_ASSERTIONS
	a_take_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid)
		else $error("back end took a job from an empty queue");

	a_escape_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.escaped) |-> (result.escape_mag_sq > etf_pkg::ESC_LIMIT))
		else $error("escaped result below escape limit");

	a_no_escape_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.escaped) |-> (result.escape_mag_sq == 64'd0))
		else $error("non-escaped result carries a magnitude");

	a_min_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.min_mag_sq <= etf_pkg::LOW_START))
		else $error("minimum magnitude above start value");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for escape_time_fractal_iterator_core
// Pushes complex points through the core under several register settings and
// idle patterns, predicts every escape-time result with a saturating Q8.56
// iterator of its own and checks the popped results in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int  HALF_PERIOD = 10;
	localparam int  CYCLE_LIMIT = 8000000;
	localparam logic signed [63:0] QMAX = 64'sh7fffffffffffffff;
	localparam logic signed [63:0] QMIN = 64'sh8000000000000000;
	localparam logic signed [63:0] ONE  = 64'sh0100000000000000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	etf_pkg::point_t     point = '0;
	logic                empty;
	logic                pop = 1'b0;
	etf_pkg::result_t    result;
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_index = etf_pkg::REG_DEGREE;
	logic [63:0]         cfg_data = '0;

	escape_time_fractal_iterator_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .point(point),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register shadow of the core
	logic [2:0]  sh_degree = etf_pkg::RST_DEGREE;
	logic [19:0] sh_formula = '0;
	logic [1:0]  sh_julia = '0;
	logic signed [63:0] sh_param_re = '0;
	logic signed [63:0] sh_param_im = '0;
	logic [15:0] sh_max_iter = etf_pkg::RST_MAX_ITER;

	etf_pkg::point_t  points_to_send[$];
	etf_pkg::result_t pixel_expect_q[$];
	int      mismatches = 0;
	int      cycles = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      recv_hold_left = 0;
	logic    sat_hit;

	always #HALF_PERIOD clk = ~clk;

	// ---------------- saturating Q8.56 arithmetic ----------------
	function automatic logic signed [63:0] q_neg(logic signed [63:0] a);
		if (a == QMIN) begin
			sat_hit = 1'b1;
			return QMAX;
		end
		return -a;
	endfunction

	function automatic logic signed [63:0] q_abs(logic signed [63:0] a);
		return a < 0 ? q_neg(a) : a;
	endfunction

	function automatic logic signed [63:0] q_clip(logic signed [71:0] s);
		if (s > 72'(QMAX)) begin
			sat_hit = 1'b1;
			return QMAX;
		end
		if (s < 72'(QMIN)) begin
			sat_hit = 1'b1;
			return QMIN;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
		return q_clip(72'(a) + 72'(b));
	endfunction

	function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
		return q_clip(72'(a) - 72'(b));
	endfunction

	function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
		logic [63:0]  ma, mb, lim;
		logic [127:0] p;
		logic         n;
		ma = a[63] ? 64'd0 - a : a;
		mb = b[63] ? 64'd0 - b : b;
		p = ({64'd0, ma} * {64'd0, mb}) >> etf_pkg::FB;
		n = a[63] ^ b[63];
		lim = n ? 64'h8000000000000000 : 64'h7fffffffffffffff;
		if (p > {64'd0, lim}) begin
			sat_hit = 1'b1;
			p = {64'd0, lim};
		end
		return n ? 64'd0 - p[63:0] : p[63:0];
	endfunction

	function automatic logic signed [63:0] q_m3(logic signed [63:0] a, b, c);
		return q_mul(q_mul(a, b), c);
	endfunction

	function automatic logic signed [63:0] q_m4(logic signed [63:0] a, b, c, d);
		return q_mul(q_m3(a, b, c), d);
	endfunction

	function automatic logic signed [63:0] q_m5(logic signed [63:0] a, b, c, d, e);
		return q_mul(q_m4(a, b, c, d), e);
	endfunction

	// factor, optionally replaced by its absolute value
	function automatic logic signed [63:0] fac(logic signed [63:0] x, int bitn);
		return sh_formula[bitn] ? q_abs(x) : x;
	endfunction

	// coefficient multiply then optional negation
	function automatic logic signed [63:0] term(int k, int bitn, logic signed [63:0] x);
		logic signed [63:0] r;
		r = q_clip(72'(x) * 72'(k));
		return sh_formula[bitn] ? q_neg(r) : r;
	endfunction

	function automatic logic signed [63:0] outer_part(logic signed [63:0] x, int absb, int sgnb);
		return term(1, sgnb, sh_formula[absb] ? q_abs(x) : x);
	endfunction

	function automatic logic [63:0] mag_sq(logic signed [63:0] r, logic signed [63:0] i);
		logic [63:0]  mr, mi;
		logic [128:0] s;
		mr = r[63] ? 64'd0 - r : r;
		mi = i[63] ? 64'd0 - i : i;
		s = (129'(mr) * 129'(mr) + 129'(mi) * 129'(mi)) >> etf_pkg::MAG_SHIFT;
		return (s[128:64] != 0) ? '1 : s[63:0];
	endfunction

	// run one pixel through the escape-time loop
	function automatic etf_pkg::result_t predict_pixel(etf_pkg::point_t p);
		etf_pkg::result_t res;
		logic signed [63:0] zr, zi, cr, ci, r, i, nr, ni;
		logic [63:0] zs;
		res.escaped = 1'b0;
		res.escape_iter = sh_max_iter;
		res.escape_mag_sq = '0;
		res.min_mag_sq = etf_pkg::LOW_START;
		if (sh_julia[0]) begin
			zr = p.point_re; zi = p.point_im; cr = sh_param_re; ci = sh_param_im;
		end else begin
			cr = p.point_re; ci = p.point_im;
			zr = sh_julia[1] ? 64'sd0 : sh_param_re;
			zi = sh_julia[1] ? 64'sd0 : sh_param_im;
		end
		for (int it = 0; it < sh_max_iter; it++) begin
			sat_hit = 1'b0;
			r = zr;
			i = zi;
			case (sh_degree)
				3'd3: begin
					nr = q_sub(term(1, 0, q_m3(fac(r, 6), r, r)),
						term(3, 1, q_m3(fac(r, 8), fac(i, 7), i)));
					ni = q_sub(term(3, 2, q_m3(fac(r, 10), r, fac(i, 9))),
						term(1, 3, q_m3(fac(i, 11), i, i)));
					nr = outer_part(nr, 12, 4);
					ni = outer_part(ni, 13, 5);
				end
				3'd4: begin
					nr = q_sub(term(1, 0, q_m4(fac(r, 7), r, r, r)),
						term(6, 1, q_m4(fac(r, 9), r, fac(i, 8), i)));
					nr = q_add(nr, term(1, 2, q_m4(fac(i, 10), i, i, i)));
					ni = q_sub(term(4, 3, q_m4(fac(r, 11), r, r, fac(i, 12))),
						term(4, 4, q_m4(fac(r, 13), fac(i, 14), i, i)));
					nr = outer_part(nr, 15, 5);
					ni = outer_part(ni, 16, 6);
				end
				3'd5: begin
					nr = q_sub(term(1, 0, q_m5(fac(r, 8), r, r, r, r)),
						term(10, 1, q_m5(fac(r, 10), r, r, fac(i, 9), i)));
					nr = q_add(nr, term(5, 2, q_m5(fac(r, 12), fac(i, 11), i, i, i)));
					ni = q_sub(term(5, 3, q_m5(fac(r, 14), r, r, r, fac(i, 13))),
						term(10, 4, q_m5(fac(r, 16), r, fac(i, 15), i, i)));
					ni = q_add(ni, term(1, 5, q_m5(fac(i, 17), i, i, i, i)));
					nr = outer_part(nr, 18, 6);
					ni = outer_part(ni, 19, 7);
				end
				default: begin
					nr = q_sub(q_mul(fac(r, 3), r), term(1, 1, q_mul(fac(i, 4), i)));
					nr = outer_part(nr, 7, 0);
					ni = term(2, 2, q_mul(fac(r, 5), fac(i, 6)));
				end
			endcase
			zr = q_add(nr, cr);
			zi = q_add(ni, ci);
			zs = mag_sq(zr, zi);
			if (sat_hit)
				zs = '1;
			if (zs < res.min_mag_sq) begin
				res.min_mag_sq = zs;
			end else if (zs > etf_pkg::ESC_LIMIT) begin
				res.escaped = 1'b1;
				res.escape_iter = it[15:0];
				res.escape_mag_sq = zs;
				break;
			end
		end
		return res;
	endfunction

	// ---------------- request driver ----------------
	always @(posedge clk) begin
		logic taken;
		taken = push && !full;
		if (taken) begin
			pixel_expect_q.push_back(predict_pixel(point));
			void'(points_to_send.pop_front());
		end
		if (!push || taken) begin
			if (points_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				point <= points_to_send[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ---------------- result monitor ----------------
	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		etf_pkg::result_t want;
		if (pop && !empty) begin
			if (pixel_expect_q.size() == 0) begin
				report("unexpected result", result.escape_iter, 64'd0);
			end else begin
				want = pixel_expect_q.pop_front();
				if (result.escaped !== want.escaped)
					report("escaped", result.escaped, want.escaped);
				if (result.escape_iter !== want.escape_iter)
					report("escape_iter", result.escape_iter, want.escape_iter);
				if (result.escape_mag_sq !== want.escape_mag_sq)
					report("escape_mag_sq", result.escape_mag_sq, want.escape_mag_sq);
				if (result.min_mag_sq !== want.min_mag_sq)
					report("min_mag_sq", result.min_mag_sq, want.min_mag_sq);
			end
		end
		// hold off for a long stretch when asked, else stall at random
		if (recv_hold_left > 0) begin
			recv_hold_left <= recv_hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(etf_pkg::cfg_reg_e idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			etf_pkg::REG_DEGREE:   sh_degree = val[2:0];
			etf_pkg::REG_FORMULA:  sh_formula = val[19:0];
			etf_pkg::REG_JULIA:    sh_julia = val[1:0];
			etf_pkg::REG_PARAM_RE: sh_param_re = val;
			etf_pkg::REG_PARAM_IM: sh_param_im = val;
			etf_pkg::REG_MAX_ITER: sh_max_iter = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_point(logic signed [63:0] re, logic signed [63:0] im);
		etf_pkg::point_t p;
		p.point_re = re;
		p.point_im = im;
		points_to_send.push_back(p);
	endtask

	// wait until every request is in and every result is out
	task automatic drain();
		while (points_to_send.size() > 0 || pixel_expect_q.size() > 0 || push)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly points near the set, sometimes any 64-bit value
	function automatic logic signed [63:0] rand_coord(int wide_pct);
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(99) >= wide_pct)
			v = v >>> $urandom_range(5, 8);
		return v;
	endfunction

	initial begin
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: plain quadratic, budget 256
		add_point(0, 0);
		add_point(QMAX, QMAX);
		add_point(QMIN, QMIN);
		add_point(QMIN, 0);
		add_point(-2 * ONE, 0);
		add_point(ONE / 4, 0);
		add_point(ONE, ONE);
		add_point(-ONE, 0);
		drain();

		// budget zero, then the largest budget with points that escape well before it
		write_reg(etf_pkg::REG_MAX_ITER, 0);
		add_point(ONE / 8, -ONE / 8);
		add_point(QMIN, QMAX);
		drain();
		write_reg(etf_pkg::REG_MAX_ITER, 16'hffff);
		add_point(QMAX, 0);
		add_point(4 * ONE, -4 * ONE);
		drain();

		// cubic, quartic and quintic families with all formula bits clear and all set
		write_reg(etf_pkg::REG_MAX_ITER, 16);
		for (int d = 3; d <= 5; d++) begin
			write_reg(etf_pkg::REG_DEGREE, d);
			write_reg(etf_pkg::REG_FORMULA, 0);
			add_point(ONE / 2, ONE / 4);
			drain();
			write_reg(etf_pkg::REG_FORMULA, 20'hfffff);
			add_point(-ONE / 2, -ONE / 3);
			drain();
		end

		// julia mode with extreme parameters
		write_reg(etf_pkg::REG_JULIA, etf_pkg::JULIA_BIT);
		write_reg(etf_pkg::REG_PARAM_RE, QMAX);
		write_reg(etf_pkg::REG_PARAM_IM, QMIN);
		add_point(0, 0);
		add_point(ONE, -ONE);
		drain();

		// random phases over all idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			write_reg(etf_pkg::REG_DEGREE, $urandom_range(7));
			write_reg(etf_pkg::REG_FORMULA, $urandom);
			write_reg(etf_pkg::REG_JULIA, $urandom_range(3));
			write_reg(etf_pkg::REG_PARAM_RE, rand_coord(15));
			write_reg(etf_pkg::REG_PARAM_IM, rand_coord(15));
			write_reg(etf_pkg::REG_MAX_ITER, $urandom_range(1, 12));
			n = 60;
			for (int k = 0; k < n; k++)
				add_point(rand_coord(10), rand_coord(10));
			// receiver holds off while the sender keeps offering
			if (ph == 0)
				recv_hold_left = 3000;
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
